// File: hw/rtl/cfid_pkg.sv
`timescale 1ns / 1ps

package cfid_pkg;

  localparam int ID_FIELD_W  = 13;
  localparam int COARSE_W    = 3;
  localparam int HALF_W      = 32;
  localparam int KEY_W       = 2 * HALF_W;
  localparam int ENC_W       = COARSE_W + ID_FIELD_W;
  localparam int MAX_IDS_DEF = 256;

  typedef enum logic {
    CMD_MAP   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_QRD1,
    ST_QRD2,
    ST_QCMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [COARSE_W-1:0]    coarse_layer;
    logic [HALF_W-1:0]      layer_bits;
    logic [HALF_W-1:0]      mask_bits;
    logic [ENC_W-1:0]       first_encoded;
    logic [ENC_W-1:0]       second_encoded;
  } in_word_t;

  typedef struct packed {
    logic [ENC_W-1:0] encoded_layer;
    logic             table_full;
    logic             collides;
  } out_word_t;

endpackage

// File: hw/rtl/cfid_key_ram.sv
`timescale 1ns / 1ps

module cfid_key_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/collision_filter_id_table_core.sv
`timescale 1ns / 1ps

// collision filter id table: hands out sequential ids for 64-bit keys (32-bit
// collision layer over 32-bit mask) and answers pair-collision queries on ids.
// A map word scans the stored keys one per cycle through the single read port
// of the key memory with one shared 64-bit comparator; a hit reuses its id, a
// miss appends the key under the next id, and a miss on a full table returns 0
// with table_full set. A map word passes through the scan, one stored key read
// per cycle, a drain of the last read and the done state; a query word passes
// through two reads of the same port, one compare and the done state. The done
// state stretches while an earlier result still waits in the output register.
// in_ready is high only while the block is idle; the finished word sits in an
// output register, so a new word is taken while the previous result waits for
// out_ready. The key memory needs no clearing pass: only entries below the id
// count are read, and ids at or above the count read as the zero key and never
// collide.

module collision_filter_id_table_core
  import cfid_pkg::*;
#(
  parameter int MAX_IDS = MAX_IDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // address width of the key memory, and a counter that can hold MAX_IDS itself
  localparam int ID_W  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CNT_W = $clog2(MAX_IDS + 1);
  localparam int CMP_W = ID_FIELD_W + 1;

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] ids_used_r, ids_used_nxt;
  logic [CNT_W-1:0] issue_idx_r, issue_idx_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload held for the word in flight
  logic [COARSE_W-1:0] coarse_r, coarse_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [ID_W-1:0]     id1_r, id1_nxt;
  logic [ID_W-1:0]     id2_r, id2_nxt;
  logic                v1_r, v1_nxt;
  logic                v2_r, v2_nxt;
  logic [ID_W-1:0]     pend_idx_r, pend_idx_nxt;
  out_word_t           res_r, res_nxt;
  out_word_t           out_data_r, out_data_nxt;

  // key memory port
  logic             ram_we;
  logic [ID_W-1:0]  ram_waddr;
  logic [ID_W-1:0]  ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  // scan, handshake and query status; scan_hit comes from the one shared comparator
  logic             accept;
  logic             issue_more;
  logic             scan_hit;
  logic             scan_miss;
  logic             table_full;
  logic             out_free;
  logic [KEY_W-1:0] key2;
  logic             hit;

  assign accept     = in_valid && in_ready;
  assign issue_more = issue_idx_r < ids_used_r;
  // the single 64-bit equality compare, shared by every step of the scan
  assign scan_hit   = pend_vld_r && (ram_rdata == key_r);
  // every stored key compared and none matched
  assign scan_miss  = !pend_vld_r && !issue_more;
  assign table_full = ids_used_r == CNT_W'(MAX_IDS);
  assign out_free   = !out_valid_r || out_ready;

  // second query key arrives in the compare cycle; unassigned ids are zero
  assign key2 = v2_r ? ram_rdata : '0;
  assign hit  = ((key_r[HALF_W-1:0] & key2[KEY_W-1:HALF_W]) != '0) ||
                ((key2[HALF_W-1:0] & key_r[KEY_W-1:HALF_W]) != '0);

  cfid_key_ram #(
    .DEPTH  (MAX_IDS),
    .ADDR_W (ID_W),
    .DATA_W (KEY_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.cmd == CMD_QUERY) ? ST_QRD1 : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_miss) begin
          state_nxt = ST_DONE;
        end
      end
      ST_QRD1: state_nxt = ST_QRD2;
      ST_QRD2: state_nxt = ST_QCMP;
      ST_QCMP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ids_used_r[ID_W-1:0];
    ram_raddr = issue_idx_r[ID_W-1:0];
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: begin
        // append on a miss while ids are left
        ram_we = !scan_hit && scan_miss && !table_full;
      end
      ST_QRD1: ram_raddr = id1_r;
      ST_QRD2: ram_raddr = id2_r;
      ST_QCMP: ram_raddr = id2_r;
      ST_DONE: ram_raddr = issue_idx_r[ID_W-1:0];
      default: in_ready = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    ids_used_nxt  = ids_used_r;
    issue_idx_nxt = issue_idx_r;
    pend_vld_nxt  = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    coarse_nxt    = coarse_r;
    key_nxt       = key_r;
    id1_nxt       = id1_r;
    id2_nxt       = id2_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          coarse_nxt    = in_data.coarse_layer;
          key_nxt       = {in_data.layer_bits, in_data.mask_bits};
          id1_nxt       = in_data.first_encoded[ID_W-1:0];
          id2_nxt       = in_data.second_encoded[ID_W-1:0];
          // an id at or above the count reads as the zero key
          v1_nxt        = CMP_W'(in_data.first_encoded[ID_FIELD_W-1:0]) <
                          CMP_W'(ids_used_r);
          v2_nxt        = CMP_W'(in_data.second_encoded[ID_FIELD_W-1:0]) <
                          CMP_W'(ids_used_r);
          issue_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          res_nxt.encoded_layer = {coarse_r, ID_FIELD_W'(pend_idx_r)};
          res_nxt.table_full    = 1'b0;
          res_nxt.collides      = 1'b0;
        end else if (scan_miss) begin
          res_nxt.collides = 1'b0;
          if (table_full) begin
            res_nxt.encoded_layer = '0;
            res_nxt.table_full    = 1'b1;
          end else begin
            res_nxt.encoded_layer = {coarse_r, ID_FIELD_W'(ids_used_r)};
            res_nxt.table_full    = 1'b0;
            ids_used_nxt          = ids_used_r + CNT_W'(1);
          end
        end else if (issue_more) begin
          // read one stored key, compare it next cycle
          pend_vld_nxt  = 1'b1;
          pend_idx_nxt  = issue_idx_r[ID_W-1:0];
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
        end
      end
      ST_QRD2: begin
        // first key is on the read data now
        key_nxt = v1_r ? ram_rdata : '0;
      end
      ST_QCMP: begin
        res_nxt.encoded_layer = '0;
        res_nxt.table_full    = 1'b0;
        res_nxt.collides      = hit;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        pend_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ids_used_r  <= '0;
      issue_idx_r <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ids_used_r  <= ids_used_nxt;
      issue_idx_r <= issue_idx_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coarse_r   <= coarse_nxt;
    key_r      <= key_nxt;
    id1_r      <= id1_nxt;
    id2_r      <= id2_nxt;
    v1_r       <= v1_nxt;
    v2_r       <= v2_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/cfid_checker.sv
`timescale 1ns / 1ps

module cfid_checker
  import cfid_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a full-table miss carries no id and no collision
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |->
      out_data.encoded_layer == '0 && !out_data.collides)
    else $error("full flag with other fields set");

  // a collision comes only from a query, whose other fields are zero
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.collides |->
      out_data.encoded_layer == '0 && !out_data.table_full)
    else $error("collision with map fields set");

  // the block works on one word at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word taken while busy");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word out of reset");

endmodule

bind collision_filter_id_table_core cfid_checker u_cfid_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import cfid_pkg::*;

  localparam int TABLE_DEPTH  = MAX_IDS_DEF;
  localparam int RANDOM_WORDS = 1485;
  localparam int QUIET_FROM   = 30000;
  localparam int QUIET_TO     = 90000;
  localparam int DRAIN_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  collision_filter_id_table_core #(
    .MAX_IDS(TABLE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // words waiting to go in, and answers waiting to come out
  in_word_t  words_to_send[$];
  out_word_t answers_due[$];

  // shadow copy of the id table
  logic [KEY_W-1:0] layer_mask_keys[TABLE_DEPTH];
  int               ids_given = 0;

  int errors = 0;
  int words_total = 0;
  int words_taken = 0;
  int cyc = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // reset held low at the start, then released for good
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // idle about 8 percent of the time, none inside the quiet window
  function automatic bit take_break();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 8;
  endfunction

  // half-key values: dense, one-hot, zero or sparse, so collisions go both ways
  function automatic logic [HALF_W-1:0] rand_half();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'h1 << $urandom_range(0, 31);
      2: return '0;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  // map word; query fields carry junk since the block must ignore them
  function automatic in_word_t map_word(input logic [COARSE_W-1:0] coarse,
                                        input logic [HALF_W-1:0] layer,
                                        input logic [HALF_W-1:0] mask);
    in_word_t w;
    w.cmd            = CMD_MAP;
    w.coarse_layer   = coarse;
    w.layer_bits     = layer;
    w.mask_bits      = mask;
    w.first_encoded  = ENC_W'($urandom);
    w.second_encoded = ENC_W'($urandom);
    return w;
  endfunction

  // query word; map fields carry junk
  function automatic in_word_t query_word(input logic [ENC_W-1:0] first,
                                          input logic [ENC_W-1:0] second);
    in_word_t w;
    w.cmd            = CMD_QUERY;
    w.coarse_layer   = COARSE_W'($urandom);
    w.layer_bits     = $urandom;
    w.mask_bits      = $urandom;
    w.first_encoded  = first;
    w.second_encoded = second;
    return w;
  endfunction

  // key behind an id; ids not handed out yet stand for the zero key
  function automatic logic [KEY_W-1:0] key_for(input logic [ENC_W-1:0] enc);
    int id;
    id = int'(enc[ID_FIELD_W-1:0]);
    if (id >= ids_given || id >= TABLE_DEPTH) return '0;
    return layer_mask_keys[id];
  endfunction

  // answer the block owes for one word; a map may grow the shadow table
  function automatic out_word_t table_answer(input in_word_t w);
    out_word_t        a;
    logic [KEY_W-1:0] key, k1, k2;
    int               id;
    a  = '0;
    id = -1;
    if (w.cmd == CMD_MAP) begin
      key = {w.layer_bits, w.mask_bits};
      for (int i = 0; i < ids_given; i++) begin
        if (layer_mask_keys[i] == key) begin
          id = i;
          break;
        end
      end
      if (id < 0) begin
        if (ids_given >= TABLE_DEPTH) begin
          a.table_full = 1'b1;
        end else begin
          id = ids_given;
          layer_mask_keys[id] = key;
          ids_given++;
        end
      end
      if (id >= 0) a.encoded_layer = {w.coarse_layer, ID_FIELD_W'(id)};
    end else begin
      k1 = key_for(w.first_encoded);
      k2 = key_for(w.second_encoded);
      // layer sits in the high half, mask in the low half
      a.collides = ((k1[HALF_W-1:0] & k2[KEY_W-1:HALF_W]) != '0) ||
                   ((k2[HALF_W-1:0] & k1[KEY_W-1:HALF_W]) != '0);
    end
    return a;
  endfunction

  // stimulus: directed words first, then the random mix
  initial begin
    logic [KEY_W-1:0] used_keys[$];
    logic [HALF_W-1:0] lay, msk;
    logic [KEY_W-1:0] k;
    logic [ENC_W-1:0] e1, e2;
    int               pick;

    // query on an empty table, upper bits set: nothing assigned, no collision
    words_to_send.push_back(query_word(16'hFFFF, 16'h0000));
    // extremes of the key halves and of the coarse layer
    words_to_send.push_back(map_word(3'd0, 32'h0000_0000, 32'h0000_0000));  // id 0
    words_to_send.push_back(map_word(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));  // id 1
    words_to_send.push_back(map_word(3'd3, 32'h0000_0001, 32'h8000_0000));  // id 2
    words_to_send.push_back(map_word(3'd5, 32'h8000_0000, 32'h0000_0001));  // id 3
    // known keys come back with their old ids under a new coarse layer
    words_to_send.push_back(map_word(3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    words_to_send.push_back(map_word(3'd7, 32'h0000_0000, 32'h0000_0000));
    // self overlap, overlap both ways, zero key, no overlap
    words_to_send.push_back(query_word(16'h0001, 16'h0001));
    words_to_send.push_back(query_word(16'hE002, 16'hA003));
    words_to_send.push_back(query_word(16'h0000, 16'h2001));
    words_to_send.push_back(query_word(16'h0002, 16'h0002));
    // ids past the count never collide, top id value included
    words_to_send.push_back(query_word(16'h0001, 16'h0004));
    words_to_send.push_back(query_word(16'h1FFF, 16'h0001));
    words_to_send.push_back(map_word(3'd1, 32'h0000_0000, 32'hFFFF_FFFF));  // id 4
    words_to_send.push_back(query_word(16'h0004, 16'hC001));
    used_keys.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
    used_keys.push_back({32'h0000_0001, 32'h8000_0000});

    // random part: new keys fill the table and then run into the full case
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        lay = rand_half();
        msk = rand_half();
        used_keys.push_back({lay, msk});
        words_to_send.push_back(map_word(COARSE_W'($urandom_range(0, 7)), lay, msk));
      end else if (pick < 70) begin
        k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        words_to_send.push_back(map_word(COARSE_W'($urandom_range(0, 7)),
                                         k[KEY_W-1:HALF_W], k[HALF_W-1:0]));
      end else begin
        // mostly ids near the assigned range, sometimes anything
        e1 = ENC_W'($urandom);
        e2 = ENC_W'($urandom);
        if ($urandom_range(0, 9) < 8)
          e1[ID_FIELD_W-1:0] = ID_FIELD_W'($urandom_range(0, 299));
        if ($urandom_range(0, 9) < 8)
          e2[ID_FIELD_W-1:0] = ID_FIELD_W'($urandom_range(0, 299));
        words_to_send.push_back(query_word(e1, e2));
      end
    end
    words_total = words_to_send.size();
  end

  // driver: one word at a time, held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        answers_due.push_back(table_answer(in_data));
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (words_to_send.size() > 0 && !take_break()) begin
          in_data  <= words_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word against the oldest answer due
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          flag_mismatch($sformatf("result %h with nothing outstanding", out_data));
        end else begin
          want = answers_due.pop_front();
          if (out_data.encoded_layer !== want.encoded_layer)
            flag_mismatch($sformatf("encoded_layer %h, want %h",
                                    out_data.encoded_layer, want.encoded_layer));
          if (out_data.table_full !== want.table_full)
            flag_mismatch($sformatf("table_full %b, want %b",
                                    out_data.table_full, want.table_full));
          if (out_data.collides !== want.collides)
            flag_mismatch($sformatf("collides %b, want %b",
                                    out_data.collides, want.collides));
        end
      end
      out_ready <= !take_break();
    end
  end

  // end of run: everything sent, everything answered, then a short drain
  initial begin
    @(posedge rst_n);
    @(negedge clk);
    while (words_taken < words_total || answers_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
